[src/sci_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_pkg: shared types for the section crossing interpolator
// Holds the control word that the sequencer sends to every lane.
// ----------------------------------------------------------------------------
package sci_pkg;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic combine;
		logic div_step;
	} lane_ctl_t;

endpackage

[src/section_crossing_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// section_crossing_interpolator: Poincare section y = 0 crossing detector
// Three lanes interpolate x, z and w at the crossing; a sequencer steps them
// and a merging output register presents one result word per sample word.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel (sample_valid/sample_ready) takes one word of start_trace
//   and sample_x..sample_w. Result channel (result_valid/result_ready) gives
//   one word per sample: crossed and cross_x, cross_z, cross_w.
//   A sample without a crossing passes through the hand-off state into the
//   output register, and the next sample is taken after the hand-off.
//   A crossing runs SAMPLE_WIDTH shift-add multiply steps, one combine
//   step, SAMPLE_WIDTH divide steps and one hand-off step; the next sample
//   is taken once the hand-off has loaded the output register.
//   One sample is in work at a time; sample_ready is high whenever the
//   lanes are free, even while a finished result waits in the output
//   register. A stalled receiver holds the finished result in the lanes, so
//   at most one more sample can be taken before sample_ready drops.
//   Reset clears the previous sample and the primed flag and empties the
//   output register; the first sample after reset only primes the store.
// ----------------------------------------------------------------------------
module section_crossing_interpolator #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic                           start_trace,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_x,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_y,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_z,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_w,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           crossed,
	output logic signed [SAMPLE_WIDTH-1:0] cross_x,
	output logic signed [SAMPLE_WIDTH-1:0] cross_z,
	output logic signed [SAMPLE_WIDTH-1:0] cross_w
);
	import sci_pkg::*;

	localparam int W  = SAMPLE_WIDTH;
	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_COMB = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_HOLD = 3'd4;

	logic [2:0]            state_q;
	logic [CW-1:0]         step_cnt_q;
	logic                  cross_pend_q;
	logic                  primed_q;
	logic signed [W-1:0]   prev_x_q;
	logic signed [W-1:0]   prev_y_q;
	logic signed [W-1:0]   prev_z_q;
	logic signed [W-1:0]   prev_w_q;
	logic                  result_valid_q;
	logic                  crossed_out_q;
	logic signed [W-1:0]   cross_x_q;
	logic signed [W-1:0]   cross_z_q;
	logic signed [W-1:0]   cross_w_q;

	logic                  accept_c;
	logic                  cross_c;
	logic                  out_load_c;
	logic [W-1:0]          py_c;
	logic [W-1:0]          dy_c;
	lane_ctl_t             ctl_c;
	logic signed [W-1:0]   lane_x_c;
	logic signed [W-1:0]   lane_z_c;
	logic signed [W-1:0]   lane_w_c;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept_c     = sample_valid && sample_ready;
	assign cross_c      = !start_trace && primed_q && !prev_y_q[W-1] &&
	                      (prev_y_q != '0) && sample_y[W-1];
	assign out_load_c   = (state_q == ST_HOLD) && (!result_valid_q || result_ready);

	assign py_c = prev_y_q;
	assign dy_c = ~sample_y + W'(1);

	assign ctl_c.load     = accept_c && cross_c;
	assign ctl_c.mul_step = (state_q == ST_MUL);
	assign ctl_c.combine  = (state_q == ST_COMB);
	assign ctl_c.div_step = (state_q == ST_DIV);

	sci_lane #(.SAMPLE_WIDTH(W)) u_lane_x (
		.clk    (clk),
		.ctl    (ctl_c),
		.prev   (prev_x_q),
		.cur    (sample_x),
		.py     (py_c),
		.dy     (dy_c),
		.result (lane_x_c)
	);

	sci_lane #(.SAMPLE_WIDTH(W)) u_lane_z (
		.clk    (clk),
		.ctl    (ctl_c),
		.prev   (prev_z_q),
		.cur    (sample_z),
		.py     (py_c),
		.dy     (dy_c),
		.result (lane_z_c)
	);

	sci_lane #(.SAMPLE_WIDTH(W)) u_lane_w (
		.clk    (clk),
		.ctl    (ctl_c),
		.prev   (prev_w_q),
		.cur    (sample_w),
		.py     (py_c),
		.dy     (dy_c),
		.result (lane_w_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_cnt_q   <= '0;
			cross_pend_q <= 1'b0;
			primed_q     <= 1'b0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_z_q     <= '0;
			prev_w_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept_c) begin
						cross_pend_q <= cross_c;
						primed_q     <= 1'b1;
						prev_x_q     <= sample_x;
						prev_y_q     <= sample_y;
						prev_z_q     <= sample_z;
						prev_w_q     <= sample_w;
						step_cnt_q   <= '0;
						state_q      <= cross_c ? ST_MUL : ST_HOLD;
					end
				end
				ST_MUL: begin
					if (step_cnt_q == LAST_STEP) begin
						step_cnt_q <= '0;
						state_q    <= ST_COMB;
					end else begin
						step_cnt_q <= step_cnt_q + CW'(1);
					end
				end
				ST_COMB: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_cnt_q == LAST_STEP) begin
						step_cnt_q <= '0;
						state_q    <= ST_HOLD;
					end else begin
						step_cnt_q <= step_cnt_q + CW'(1);
					end
				end
				ST_HOLD: begin
					if (out_load_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					step_cnt_q <= '0;
				end
			endcase
		end
	end

	// merge the lanes into the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load_c) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load_c) begin
			crossed_out_q <= cross_pend_q;
			cross_x_q     <= cross_pend_q ? lane_x_c : '0;
			cross_z_q     <= cross_pend_q ? lane_z_c : '0;
			cross_w_q     <= cross_pend_q ? lane_w_c : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign crossed      = crossed_out_q;
	assign cross_x      = cross_x_q;
	assign cross_z      = cross_z_q;
	assign cross_w      = cross_w_q;

`ifndef SYNTH
	a_no_cross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !crossed |-> cross_x == '0 && cross_z == '0 && cross_w == '0)
		else $error("non-crossing word carries nonzero fields");

	a_cross_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept_c && cross_c |=> state_q == ST_MUL && !sample_ready)
		else $error("crossing word did not start the lanes");

	a_hold_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_HOLD) |-> $past(state_q) == ST_DIV || $past(state_q) == ST_IDLE)
		else $error("hand-off entered from a wrong state");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> step_cnt_q == '0)
		else $error("step counter not cleared in idle");
`endif

endmodule

[src/sci_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_lane: one interpolation lane
// Forms py*cur - prev*cy with two shift-add multipliers, then divides the
// magnitude by py - cy with a restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module sci_lane #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  sci_pkg::lane_ctl_t             ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] prev,
	input  logic signed [SAMPLE_WIDTH-1:0] cur,
	input  logic        [SAMPLE_WIDTH-1:0] py,
	input  logic        [SAMPLE_WIDTH-1:0] dy,
	output logic signed [SAMPLE_WIDTH-1:0] result
);
	import sci_pkg::*;

	localparam int W  = SAMPLE_WIDTH;
	localparam int NW = 2 * W + 1;

	logic signed [NW-1:0] mcand_a_q;
	logic signed [NW-1:0] mcand_b_q;
	logic        [W-1:0]  mplier_a_q;
	logic        [W-1:0]  mplier_b_q;
	logic signed [NW-1:0] acc_a_q;
	logic signed [NW-1:0] acc_b_q;
	logic        [W:0]    den_q;
	logic                 neg_q;
	logic        [W-1:0]  rem_q;
	logic        [W-1:0]  quo_q;

	logic signed [NW-1:0] sum_c;
	logic        [NW-1:0] mag_c;
	logic        [W:0]    rem2_c;
	logic        [W:0]    diff_c;
	logic                 ge_c;
	logic        [W-1:0]  rem_nx_c;
	logic        [W-1:0]  quo_neg_c;

	// cur*py + prev*(-cy) equals py*cur - prev*cy
	assign sum_c     = acc_a_q + acc_b_q;
	assign mag_c     = sum_c[NW-1] ? (~sum_c + NW'(1)) : sum_c;
	assign rem2_c    = {rem_q, quo_q[W-1]};
	assign ge_c      = (rem2_c >= den_q);
	assign diff_c    = rem2_c - den_q;
	assign rem_nx_c  = ge_c ? diff_c[W-1:0] : rem2_c[W-1:0];
	assign quo_neg_c = ~quo_q + W'(1);
	assign result    = neg_q ? $signed(quo_neg_c) : $signed(quo_q);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mcand_a_q  <= NW'(cur);
			mcand_b_q  <= NW'(prev);
			mplier_a_q <= py;
			mplier_b_q <= dy;
			acc_a_q    <= '0;
			acc_b_q    <= '0;
			den_q      <= {1'b0, py} + {1'b0, dy};
		end else if (ctl.mul_step) begin
			if (mplier_a_q[0]) begin
				acc_a_q <= acc_a_q + mcand_a_q;
			end
			if (mplier_b_q[0]) begin
				acc_b_q <= acc_b_q + mcand_b_q;
			end
			mcand_a_q  <= mcand_a_q <<< 1;
			mcand_b_q  <= mcand_b_q <<< 1;
			mplier_a_q <= mplier_a_q >> 1;
			mplier_b_q <= mplier_b_q >> 1;
		end else if (ctl.combine) begin
			// upper half is below the divisor since the quotient fits
			neg_q <= sum_c[NW-1];
			rem_q <= mag_c[2*W-1:W];
			quo_q <= mag_c[W-1:0];
		end else if (ctl.div_step) begin
			rem_q <= rem_nx_c;
			quo_q <= {quo_q[W-2:0], ge_c};
		end
	end

endmodule
